// File: rtl/core/asid_sx_pkg.sv
// Package for the ASID SysEx register decoder: codes, constants and types.
// Used by the front, queue, back and top files under rtl/core; depends on nothing.
package asid_sx_pkg;

    localparam int MAX_MSG_BYTES_DEF = 64;

    // Message framing and type bytes
    localparam logic [7:0] SYSEX_START  = 8'hf0;
    localparam logic [7:0] MAKER_ID     = 8'h2d;
    localparam logic [7:0] SYSEX_END    = 8'hf7;
    localparam logic [7:0] TYPE_START   = 8'h4c;
    localparam logic [7:0] TYPE_STOP    = 8'h4d;
    localparam logic [7:0] TYPE_DISPLAY = 8'h4f;
    localparam logic [7:0] TYPE_SID     = 8'h4e;
    localparam logic [7:0] MSB_FLAG     = 8'h80;

    // Message layout
    localparam int HDR_BYTES  = 11;  // positions 0..10 sit ahead of the data
    localparam int TYPE_POS   = 2;
    localparam int MASK_POS   = 3;
    localparam int MSB_POS    = 7;
    localparam int DATA_POS   = 11;
    localparam int MASK_BYTES = 4;
    localparam int BITS_PER   = 7;
    localparam int NUM_IDS    = MASK_BYTES * BITS_PER;  // 28

    typedef enum logic [2:0] {
        ST_START      = 3'd0,
        ST_STOP       = 3'd1,
        ST_DISPLAY    = 3'd2,
        ST_SID_DATA   = 3'd3,
        ST_BAD_FORMAT = 3'd4,
        ST_BAD_TYPE   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_READ,
        BK_EMIT,
        BK_STATUS
    } back_state_t;

    // One decoded message handed from the front to the back
    typedef struct packed {
        logic                 sid;
        status_t              status;
        logic [NUM_IDS-1:0]   mask;
        logic [NUM_IDS-1:0]   msb;
        logic [4:0]           avail;  // data bytes present, saturated at NUM_IDS
    } job_t;

endpackage

// File: rtl/core/asid_sx_if.sv
// Handshake channels of the ASID SysEx decoder: message bytes in, items out.
// Depends on nothing.
interface asid_sx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface asid_sx_out_if;
    logic       valid;
    logic       ready;
    logic       run_end;
    logic [4:0] reg_id;
    logic [7:0] reg_value;
    logic [2:0] status;
    logic       short_data;

    modport source (output valid, output run_end, output reg_id, output reg_value,
                    output status, output short_data, input ready);
    modport sink   (input valid, input run_end, input reg_id, input reg_value,
                    input status, input short_data, output ready);
endinterface

// File: rtl/core/asid_sx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module asid_sx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/asid_sx_front.sv
// Front end: loads message bytes into the store, keeps the header bytes,
// classifies the message on its last byte. Depends on asid_sx_pkg.
module asid_sx_front #(
    parameter int MAX_MSG_BYTES = asid_sx_pkg::MAX_MSG_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    asid_sx_in_if.sink                       msg,
    output logic                             ram_wr_en,
    output logic [$clog2(MAX_MSG_BYTES)-1:0] ram_wr_addr,
    output logic [7:0]                       ram_wr_data,
    output logic                             job_push,
    output asid_sx_pkg::job_t                job,
    input  logic                             queue_full,
    input  logic                             sid_done
);

    localparam int CW = $clog2(MAX_MSG_BYTES + 1);
    localparam int AW = $clog2(MAX_MSG_BYTES);
    localparam int HB = asid_sx_pkg::HDR_BYTES;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [7:0]    hdr_reg [HB];
    logic          lock_reg;
    logic          lock_next;

    logic          accept;
    logic          kept;
    logic [7:0]    hv [HB];
    logic [CW-1:0] diff;
    logic          fmt_ok;

    assign msg.ready = !lock_reg && !queue_full;
    assign accept    = msg.valid && msg.ready;
    assign kept      = cnt_reg < CW'(MAX_MSG_BYTES);

    assign ram_wr_en   = accept && kept;
    assign ram_wr_addr = cnt_reg[AW-1:0];
    assign ram_wr_data = msg.data_byte;

    // Header view as the store holds it once this byte is in
    always_comb
    begin
        for (int p = 0; p < HB; p++)
        begin
            if (CW'(p) < cnt_reg)
            begin
                hv[p] = hdr_reg[p];
            end
            else if (CW'(p) == cnt_reg)
            begin
                hv[p] = msg.data_byte;
            end
            else
            begin
                hv[p] = 8'h00;
            end
        end
    end

    assign fmt_ok = (hv[0] == asid_sx_pkg::SYSEX_START) && (hv[1] == asid_sx_pkg::MAKER_ID)
                    && (msg.data_byte == asid_sx_pkg::SYSEX_END);
    assign diff   = cnt_reg - CW'(asid_sx_pkg::DATA_POS);

    always_comb
    begin
        job.sid    = 1'b0;
        job.status = asid_sx_pkg::ST_BAD_FORMAT;
        if (fmt_ok)
        begin
            case (hv[asid_sx_pkg::TYPE_POS])
                asid_sx_pkg::TYPE_START:   job.status = asid_sx_pkg::ST_START;
                asid_sx_pkg::TYPE_STOP:    job.status = asid_sx_pkg::ST_STOP;
                asid_sx_pkg::TYPE_DISPLAY: job.status = asid_sx_pkg::ST_DISPLAY;
                asid_sx_pkg::TYPE_SID:
                begin
                    job.status = asid_sx_pkg::ST_SID_DATA;
                    job.sid    = 1'b1;
                end
                default:                   job.status = asid_sx_pkg::ST_BAD_TYPE;
            endcase
        end
        for (int m = 0; m < asid_sx_pkg::MASK_BYTES; m++)
        begin
            for (int b = 0; b < asid_sx_pkg::BITS_PER; b++)
            begin
                job.mask[m * asid_sx_pkg::BITS_PER + b] = hv[asid_sx_pkg::MASK_POS + m][b];
                job.msb[m * asid_sx_pkg::BITS_PER + b]  = hv[asid_sx_pkg::MSB_POS + m][b];
            end
        end
        // Data runs from position 11 up to the stored end marker, or to the end of a full store
        if (cnt_reg <= CW'(asid_sx_pkg::DATA_POS))
        begin
            job.avail = 5'd0;
        end
        else if (diff > CW'(asid_sx_pkg::NUM_IDS))
        begin
            job.avail = 5'(asid_sx_pkg::NUM_IDS);
        end
        else
        begin
            job.avail = diff[4:0];
        end
    end

    assign job_push = accept && msg.last_byte;

    always_comb
    begin
        cnt_next  = cnt_reg;
        lock_next = lock_reg;
        if (accept)
        begin
            if (msg.last_byte)
            begin
                cnt_next = '0;
            end
            else if (kept)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
        // Hold the store until the back end has read out the SID data
        if (job_push && job.sid)
        begin
            lock_next = 1'b1;
        end
        else if (sid_done)
        begin
            lock_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            lock_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            lock_reg <= lock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < HB; p++)
        begin
            if (accept && (cnt_reg == CW'(p)))
            begin
                hdr_reg[p] <= msg.data_byte;
            end
        end
    end

endmodule

// File: rtl/core/asid_sx_queue.sv
// Two-entry queue of decoded messages between front and back end.
// Depends on asid_sx_pkg.
module asid_sx_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  asid_sx_pkg::job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output asid_sx_pkg::job_t head
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    asid_sx_pkg::job_t slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       fill_reg;

    assign full      = fill_reg == (PW+1)'(DEPTH);
    assign not_empty = fill_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/asid_sx_back.sv
// Back end: walks the 28 register ids of a SID data message, reads data
// bytes from the store and emits write items, then the status item.
// Depends on asid_sx_pkg.
module asid_sx_back #(
    parameter int MAX_MSG_BYTES = asid_sx_pkg::MAX_MSG_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             job_valid,
    input  asid_sx_pkg::job_t                job,
    output logic                             job_pop,
    output logic                             ram_rd_en,
    output logic [$clog2(MAX_MSG_BYTES)-1:0] ram_rd_addr,
    input  logic [7:0]                       ram_rd_data,
    output logic                             sid_done,
    asid_sx_out_if.source                    item
);

    localparam int AW  = $clog2(MAX_MSG_BYTES);
    localparam int AXW = (AW > 6) ? AW : 6;

    asid_sx_pkg::back_state_t state_reg;
    asid_sx_pkg::back_state_t state_next;
    asid_sx_pkg::job_t        job_reg;
    asid_sx_pkg::job_t        job_next;
    logic [4:0]               id_reg;
    logic [4:0]               id_next;
    logic [4:0]               k_reg;
    logic [4:0]               k_next;
    logic                     short_reg;
    logic                     short_next;
    logic [7:0]               val_reg;
    logic [7:0]               val_next;
    logic [AXW-1:0]           addr_x;

    assign addr_x      = AXW'(asid_sx_pkg::DATA_POS) + AXW'(k_reg);
    assign ram_rd_addr = addr_x[AW-1:0];

    assign item.valid      = (state_reg == asid_sx_pkg::BK_EMIT)
                             || (state_reg == asid_sx_pkg::BK_STATUS);
    assign item.run_end    = state_reg == asid_sx_pkg::BK_STATUS;
    assign item.reg_id     = item.run_end ? 5'd0 : id_reg;
    assign item.reg_value  = item.run_end ? 8'h00 : val_reg;
    assign item.status     = item.run_end ? job_reg.status : asid_sx_pkg::ST_SID_DATA;
    assign item.short_data = item.run_end && short_reg;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        id_next    = id_reg;
        k_next     = k_reg;
        short_next = short_reg;
        val_next   = val_reg;
        job_pop    = 1'b0;
        ram_rd_en  = 1'b0;
        sid_done   = 1'b0;
        case (state_reg)
            asid_sx_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    job_next   = job;
                    id_next    = '0;
                    k_next     = '0;
                    short_next = 1'b0;
                    state_next = job.sid ? asid_sx_pkg::BK_SCAN : asid_sx_pkg::BK_STATUS;
                end
            end
            asid_sx_pkg::BK_SCAN:
            begin
                if (id_reg == 5'(asid_sx_pkg::NUM_IDS))
                begin
                    state_next = asid_sx_pkg::BK_STATUS;
                end
                else if (job_reg.mask[id_reg])
                begin
                    if (k_reg < job_reg.avail)
                    begin
                        ram_rd_en  = 1'b1;
                        state_next = asid_sx_pkg::BK_READ;
                    end
                    else
                    begin
                        // Flagged but no data byte left: skip and flag
                        short_next = 1'b1;
                        k_next     = k_reg + 5'd1;
                        id_next    = id_reg + 5'd1;
                    end
                end
                else
                begin
                    id_next = id_reg + 5'd1;
                end
            end
            asid_sx_pkg::BK_READ:
            begin
                val_next   = job_reg.msb[id_reg] ? (ram_rd_data | asid_sx_pkg::MSB_FLAG)
                                                 : ram_rd_data;
                state_next = asid_sx_pkg::BK_EMIT;
            end
            asid_sx_pkg::BK_EMIT:
            begin
                if (item.ready)
                begin
                    k_next     = k_reg + 5'd1;
                    id_next    = id_reg + 5'd1;
                    state_next = asid_sx_pkg::BK_SCAN;
                end
            end
            asid_sx_pkg::BK_STATUS:
            begin
                if (item.ready)
                begin
                    sid_done   = job_reg.sid;
                    state_next = asid_sx_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = asid_sx_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asid_sx_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        id_reg    <= id_next;
        k_reg     <= k_next;
        short_reg <= short_next;
        val_reg   <= val_next;
    end

endmodule

// File: rtl/core/asid_sidex_register_decoder_core.sv
// Top level of the ASID SysEx register decoder.
// Depends on asid_sx_pkg, asid_sx_if, asid_sx_ram, asid_sx_front,
// asid_sx_queue and asid_sx_back.
// Input: bytes load at one per cycle while the store is not locked and the
// queue is not full; on the last byte the message is classified in the same
// cycle and queued. A SID data message locks the input until its status
// item is taken. The back end scans the ids, does a store read and a present
// step per write, and waits while the item channel stalls.
// Reset: byte count, queue and sequencer clear at once; the store needs none.
module asid_sysex_register_decoder_core #(
    parameter int MAX_MSG_BYTES = asid_sx_pkg::MAX_MSG_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    asid_sx_in_if.sink     msg,
    asid_sx_out_if.source  item
);

    localparam int AW = $clog2(MAX_MSG_BYTES);

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [7:0]        ram_rd_data;
    logic              job_push;
    asid_sx_pkg::job_t push_job;
    logic              queue_full;
    logic              job_pop;
    logic              job_valid;
    asid_sx_pkg::job_t head_job;
    logic              sid_done;

    // Message store: written by the front, read by the back
    asid_sx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MSG_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Load bytes and classify each message; stall while SID data is read out
    asid_sx_front #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg         (msg),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .job_push    (job_push),
        .job         (push_job),
        .queue_full  (queue_full),
        .sid_done    (sid_done)
    );

    asid_sx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .head      (head_job)
    );

    // Walk the ids and emit each transfer on the item channel
    asid_sx_back #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (head_job),
        .job_pop     (job_pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .sid_done    (sid_done),
        .item        (item)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for asid_sysex_register_decoder_core: SysEx bytes in, register writes out.
// Depends on asid_sx_pkg, asid_sx_in_if / asid_sx_out_if and the decoder RTL.
module tb_top;
    import asid_sx_pkg::*;

    localparam int STORE_BYTES  = MAX_MSG_BYTES_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;   // quiet time for stray items after the last due one
    localparam int RANDOM_BYTES = 50;

    // One item leaving the decoder, laid out as the output channel carries it
    typedef struct packed {
        logic       run_end;
        logic [4:0] reg_id;
        logic [7:0] reg_value;
        status_t    status;
        logic       short_data;
    } decoded_item_t;

    // Mirrors the decoder: buffers message bytes and, on the last byte, queues
    // the register writes and the closing status item that the message must give.
    class sysex_ledger;
        logic [7:0]    store [STORE_BYTES];
        int            fill;
        decoded_item_t due_items [$];
        int            fails;
        int            bytes_seen;
        int            writes_seen;
        int            short_runs;
        int            runs_by_status [6];

        function new();
            fill        = 0;
            fails       = 0;
            bytes_seen  = 0;
            writes_seen = 0;
            short_runs  = 0;
            foreach (runs_by_status[i])
                runs_by_status[i] = 0;
        endfunction

        task report(input string what);
            fails++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        // Positions not yet loaded read as zero
        function logic [7:0] stored(input int pos);
            return (pos < fill) ? store[pos] : 8'h00;
        endfunction

        function void note_byte(input logic [7:0] b, input logic last);
            logic       kept;
            logic       short_run;
            int         limit;
            int         used;
            status_t    st;
            logic [7:0] mask;
            logic [7:0] msb;
            logic [7:0] v;
            bytes_seen++;
            kept = 1'b0;
            if (fill < STORE_BYTES)
            begin
                store[fill] = b;
                fill++;
                kept = 1'b1;
            end
            if (!last)
                return;
            // data runs up to the stored end marker, or to the end of a full store
            limit     = kept ? fill - 1 : fill;
            short_run = 1'b0;
            used      = 0;
            if (stored(0) != SYSEX_START || stored(1) != MAKER_ID || b != SYSEX_END)
            begin
                st = ST_BAD_FORMAT;
            end
            else
            begin
                case (stored(TYPE_POS))
                    TYPE_START:   st = ST_START;
                    TYPE_STOP:    st = ST_STOP;
                    TYPE_DISPLAY: st = ST_DISPLAY;
                    TYPE_SID:
                    begin
                        st = ST_SID_DATA;
                        for (int m = 0; m < MASK_BYTES; m++)
                        begin
                            mask = stored(MASK_POS + m);
                            msb  = stored(MSB_POS + m);
                            for (int k = 0; k < BITS_PER; k++)
                            begin
                                if (mask[k])
                                begin
                                    if (DATA_POS + used < limit)
                                    begin
                                        v = stored(DATA_POS + used);
                                        if (msb[k])
                                            v = v | MSB_FLAG;
                                        due_items.push_back(decoded_item_t'({1'b0,
                                            5'(m * BITS_PER + k), v, ST_SID_DATA, 1'b0}));
                                    end
                                    else
                                    begin
                                        short_run = 1'b1;
                                    end
                                    used++;
                                end
                            end
                        end
                    end
                    default:      st = ST_BAD_TYPE;
                endcase
            end
            due_items.push_back(decoded_item_t'({1'b1, 5'd0, 8'd0, st, short_run}));
            runs_by_status[st]++;
            short_runs += short_run;
            fill = 0;
        endfunction

        task check_item(input decoded_item_t got);
            decoded_item_t want;
            if (due_items.size() == 0)
            begin
                report($sformatf("unexpected item end=%0b id=%0d value=%02h status=%0d",
                                 got.run_end, got.reg_id, got.reg_value, got.status));
                return;
            end
            want = due_items.pop_front();
            if (got.run_end !== want.run_end)
                report($sformatf("run_end %0b, want %0b", got.run_end, want.run_end));
            if (got.reg_id !== want.reg_id)
                report($sformatf("reg_id %0d, want %0d", got.reg_id, want.reg_id));
            if (got.reg_value !== want.reg_value)
                report($sformatf("reg_value %02h, want %02h (id %0d)",
                                 got.reg_value, want.reg_value, want.reg_id));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.short_data !== want.short_data)
                report($sformatf("short_data %0b, want %0b", got.short_data, want.short_data));
            if (!want.run_end)
                writes_seen++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    asid_sx_in_if  msg_if ();
    asid_sx_out_if item_if ();

    asid_sysex_register_decoder_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .item  (item_if)
    );

    sysex_ledger ledger = new();

    logic [7:0] frame [$];      // message waiting to be sent, first byte first
    int         sent_bytes;
    int         burst_left [2]; // per side: 0 sender, 1 receiver
    logic       hold_req;
    logic       holding;
    int         cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Draw the idle gap ahead of the next transfer; now and then start a
    // burst of back-to-back transfers so that gap-free stretches occur too.
    function automatic int draw_gap(input int side);
        if (burst_left[side] > 0)
        begin
            burst_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            burst_left[side] = $urandom_range(10, 30);
        return $urandom_range(0, 10);
    endfunction

    // Build a SID data message. Bit 7 of the mask and MSB bytes is noise that
    // the decoder must ignore. extra adds data bytes beyond the flagged count;
    // a negative value leaves the message short of data.
    function automatic void build_sid(input logic [27:0] mask, input logic [27:0] msb,
                                      input int extra);
        int n;
        frame = '{SYSEX_START, MAKER_ID, TYPE_SID};
        for (int m = 0; m < MASK_BYTES; m++)
            frame.push_back({1'($urandom_range(0, 1)), mask[m * BITS_PER +: BITS_PER]});
        for (int m = 0; m < MASK_BYTES; m++)
            frame.push_back({1'($urandom_range(0, 1)), msb[m * BITS_PER +: BITS_PER]});
        n = $countones(mask) + extra;
        for (int j = 0; j < n; j++)
            frame.push_back(8'($urandom));
        frame.push_back(SYSEX_END);
    endfunction

    // Offer every byte of the frame, flagging the final one; hold each byte
    // until the decoder takes it. Drive on the falling edge only.
    task automatic send_frame();
        int gap;
        foreach (frame[i])
        begin
            gap = holding ? 0 : draw_gap(0);
            repeat (gap)
            begin
                @(negedge clk);
                msg_if.valid <= 1'b0;
            end
            @(negedge clk);
            msg_if.valid     <= 1'b1;
            msg_if.data_byte <= frame[i];
            msg_if.last_byte <= (i == frame.size() - 1);
            do @(posedge clk); while (!msg_if.ready);
            sent_bytes++;
        end
        frame.delete();
    endtask

    // Receiver: random back-pressure, plus one long hold-off requested by the
    // stimulus so that the decoder's queue fills and it stalls its input.
    initial
    begin
        int gap;
        item_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                holding  = 1'b1;
                @(negedge clk);
                item_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holding = 1'b0;
            end
            gap = draw_gap(1);
            repeat (gap)
            begin
                @(negedge clk);
                item_if.ready <= 1'b0;
            end
            @(negedge clk);
            item_if.ready <= 1'b1;
            do @(posedge clk); while (!item_if.valid);
        end
    end

    // Sample both channels at the rising edge; note input before checking
    // output so a same-cycle transfer on each side is handled in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (msg_if.valid && msg_if.ready)
                ledger.note_byte(msg_if.data_byte, msg_if.last_byte);
            if (item_if.valid && item_if.ready)
                ledger.check_item(decoded_item_t'({item_if.run_end, item_if.reg_id,
                    item_if.reg_value, item_if.status, item_if.short_data}));
        end
    end

    // Watchdog: a hung handshake or a lost item ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d items still due",
                     cycles, ledger.due_items.size());
            $display("asid_sysex_register_decoder_core test failed");
            $finish;
        end
    end

    initial
    begin
        int         pick;
        int         idx;
        int         random_from;
        int         rounds;
        logic [7:0] tkind;

        rst_n             = 1'b0;
        msg_if.valid      = 1'b0;
        msg_if.data_byte  = 8'h00;
        msg_if.last_byte  = 1'b0;
        sent_bytes        = 0;
        burst_left[0]     = 0;
        burst_left[1]     = 0;
        hold_req          = 1'b0;
        holding           = 1'b0;
        cycles            = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: each message type, broken framing, short and overlong runs.
        frame = '{SYSEX_START, MAKER_ID, TYPE_START, SYSEX_END};
        send_frame();
        frame = '{SYSEX_START, MAKER_ID, TYPE_STOP, SYSEX_END};
        send_frame();
        frame = '{SYSEX_START, MAKER_ID, TYPE_DISPLAY, 8'h41, 8'h7f, SYSEX_END};
        send_frame();
        // unknown type byte at both extremes
        frame = '{SYSEX_START, MAKER_ID, 8'h00, SYSEX_END};
        send_frame();
        frame = '{SYSEX_START, MAKER_ID, 8'hff, SYSEX_END};
        send_frame();
        // wrong maker id, wrong start byte, missing end marker
        frame = '{SYSEX_START, 8'h2c, TYPE_START, SYSEX_END};
        send_frame();
        frame = '{8'h00, MAKER_ID, TYPE_START, SYSEX_END};
        send_frame();
        frame = '{SYSEX_START, MAKER_ID, TYPE_START, 8'h00};
        send_frame();
        // one-byte and truncated messages: absent positions read as zero
        frame = '{SYSEX_END};
        send_frame();
        frame = '{SYSEX_START, MAKER_ID, SYSEX_END};
        send_frame();
        frame = '{SYSEX_START, MAKER_ID, TYPE_SID, 8'h7f, SYSEX_END};
        send_frame();
        // SID data: nothing flagged, and all 28 flagged but short of data
        build_sid(28'h0, 28'h0, 0);
        send_frame();
        build_sid('1, '1, -20);
        send_frame();
        // one byte over the store so the end marker is dropped
        build_sid('1, 28'($urandom), 25);
        send_frame();
        // last byte that is not an end marker, dropped when the message overruns the store
        build_sid(28'($urandom), 28'($urandom), 40);
        frame[frame.size() - 1] = 8'h00;
        send_frame();

        // Random: mostly well-formed SID messages with random content, the rest
        // other types, corrupted framing, noise and overlong messages.
        random_from = sent_bytes;
        rounds      = 0;
        while (sent_bytes < random_from + RANDOM_BYTES)
        begin
            if (rounds == 0)
                hold_req = 1'b1;
            rounds++;
            pick = $urandom_range(0, 19);
            if (pick < 12)
            begin
                if (pick == 1)
                    build_sid(28'($urandom), 28'($urandom), $urandom_range(0, 2));
                else if (pick == 0)
                    build_sid(28'($urandom & $urandom), 28'($urandom),
                              -int'($urandom_range(1, 4)));
                else
                    build_sid(28'($urandom & $urandom), 28'($urandom), $urandom_range(0, 2));
            end
            else if (pick < 15)
            begin
                case (pick)
                    12:      tkind = TYPE_START;
                    13:      tkind = TYPE_STOP;
                    default: tkind = TYPE_DISPLAY;
                endcase
                frame = '{SYSEX_START, MAKER_ID, tkind};
                repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(0, 127)));
                frame.push_back(SYSEX_END);
            end
            else if (pick < 18)
            begin
                // flip one bit in the header, type byte or end marker
                build_sid(28'($urandom & $urandom), 28'($urandom), 0);
                idx = $urandom_range(0, 3);
                if (idx == 3)
                    idx = frame.size() - 1;
                frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (pick == 18)
            begin
                repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
            end
            else
            begin
                build_sid(28'($urandom), 28'($urandom), $urandom_range(30, 45));
            end
            send_frame();
        end

        @(negedge clk);
        msg_if.valid <= 1'b0;

        // Drain: wait for every queued item, then give stray items time to show
        while (ledger.due_items.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes in %0d messages: %0d start, %0d stop, %0d display,",
                 ledger.bytes_seen, ledger.runs_by_status.sum(),
                 ledger.runs_by_status[ST_START], ledger.runs_by_status[ST_STOP],
                 ledger.runs_by_status[ST_DISPLAY]);
        $display("%0d SID, %0d malformed, %0d unknown type; checked %0d register writes,",
                 ledger.runs_by_status[ST_SID_DATA], ledger.runs_by_status[ST_BAD_FORMAT],
                 ledger.runs_by_status[ST_BAD_TYPE], ledger.writes_seen);
        $display("%0d SID runs short of data, %0d mismatches",
                 ledger.short_runs, ledger.fails);
        if (ledger.fails == 0)
            $display("asid_sysex_register_decoder_core test passed");
        else
            $display("asid_sysex_register_decoder_core test failed");
        $finish;
    end

endmodule
